/* hw/rtl/lhsm_pkg.sv */
package lhsm_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int NUM_CNT    = 17;

    localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

    localparam logic [1:0] FUNC_PROBE = 2'd0;
    localparam logic [1:0] FUNC_MSG   = 2'd1;
    localparam logic [1:0] FUNC_PARSE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    localparam logic [4:0] C_PROBES        = 5'd0;
    localparam logic [4:0] C_DISC_FAIL     = 5'd1;
    localparam logic [4:0] C_DISC_LOSS     = 5'd2;
    localparam logic [4:0] C_DISC_RECOV    = 5'd3;
    localparam logic [4:0] C_PEER_CHG      = 5'd4;
    localparam logic [4:0] C_RPC_OK        = 5'd5;
    localparam logic [4:0] C_RPC_TIMEOUT   = 5'd6;
    localparam logic [4:0] C_RPC_TRANSPORT = 5'd7;
    localparam logic [4:0] C_RPC_OTHER     = 5'd8;
    localparam logic [4:0] C_PARSE         = 5'd9;
    localparam logic [4:0] C_STALL         = 5'd10;
    localparam logic [4:0] C_RECOVERIES    = 5'd11;
    localparam logic [4:0] C_TRANSITIONS   = 5'd12;
    localparam logic [4:0] C_MSGS          = 5'd13;
    localparam logic [4:0] C_DUPS          = 5'd14;
    localparam logic [4:0] C_LOSS          = 5'd15;
    localparam logic [4:0] C_LAT_SAMPLES   = 5'd16;
    localparam logic [4:0] SEL_RETAINED    = 5'd17;
    localparam logic [4:0] SEL_BASE_P99    = 5'd18;
    localparam logic [4:0] SEL_FINAL_P99   = 5'd19;
    localparam logic [4:0] SEL_DRIFT       = 5'd20;
    localparam logic [4:0] SEL_STATE       = 5'd21;

    localparam logic [1:0] H_STARTING = 2'd0;
    localparam logic [1:0] H_RUNNING  = 2'd1;
    localparam logic [1:0] H_DEGRADED = 2'd2;
    localparam logic [1:0] H_FAILED   = 2'd3;

    localparam logic [1:0] R_READY       = 2'd0;
    localparam logic [1:0] R_DISC_LOST   = 2'd1;
    localparam logic [1:0] R_RPC_UNAVAIL = 2'd2;
    localparam logic [1:0] R_STALLED     = 2'd3;

    localparam logic [3:0] RPC_OK         = 4'd0;
    localparam logic [3:0] RPC_TIMEOUT    = 4'd1;
    localparam logic [3:0] RPC_CLOSED     = 4'd2;
    localparam logic [3:0] RPC_TRANSPORT  = 4'd3;
    localparam logic [3:0] RPC_OTHER_LO   = 4'd4;
    localparam logic [3:0] RPC_OTHER_HI   = 4'd12;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] n;
    } p99_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } p99_rsp_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == SAT_MAX) ? v : v + 32'd1;
    endfunction

    // ceil(99n/100) = n - floor(n/100); reciprocal exact for n below 2^15
    function automatic logic [CNT_W-1:0] p99_rank(input logic [CNT_W-1:0] n);
        logic [CNT_W+12:0] prod;
        prod = {13'd0, n} * (CNT_W+13)'(5243);
        return n - CNT_W'(prod >> 19);
    endfunction

endpackage

/* hw/rtl/link_health_and_sequence_monitor.sv */
// Link health and sequence monitor.
// Input channel (in_valid / in_stall) carries one item per handshake: a probe
// report, a stream message, a parse-error total or a counter read, chosen by
// func. Output channel (out_valid / out_stall) returns exactly one result item
// for every input item, in order, from an output register.
// Probes, messages, parse totals and plain counter reads: the result is valid
// the cycle after acceptance, and a new item is taken each cycle while the
// output is not stalled.
// Reads of a p99 or the drift run a rank-selection walk over a latency RAM
// (one read port, one sample a cycle); drift runs two walks, the final window
// first and then the baseline; no item is accepted meanwhile.
// window_size is written through cfg_valid / cfg_ready (always ready); 0 acts
// as 1 and values above the window depth saturate. Write it only while idle;
// the block itself does not enforce this. Reset clears health to starting, all
// counters and fill levels; the latency RAMs need no clearing. A stalled result
// holds its fields, and input is stalled while a held result waits.
module link_health_and_sequence_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  window_size,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic        discovery_up,
    input  logic [31:0] peer_gen,
    input  logic [3:0]  rpc_code,
    input  logic        latency_present,
    input  logic [31:0] latency_ns,
    input  logic        stream_recent,
    input  logic [31:0] msg_generation,
    input  logic [31:0] msg_sequence,
    input  logic [31:0] parse_error_total,
    input  logic [4:0]  counter_select,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        transition_valid,
    output logic [1:0]  old_health,
    output logic [1:0]  new_health,
    output logic [1:0]  reason,
    output logic [31:0] transition_index,
    output logic signed [32:0] read_value
);

    localparam int CW = lhsm_pkg::CNT_W;
    localparam int AW = lhsm_pkg::ADDR_W;

    typedef enum logic [2:0] {
        P_IDLE = 3'b001,
        P_RUN1 = 3'b010,
        P_RUN2 = 3'b100
    } phase_t;

    phase_t phase_reg, phase_next;
    logic [CW-1:0] ws_reg, ws_next;
    logic [1:0]  health_reg, health_next;
    logic        fail_ep_reg, fail_ep_next;
    logic        disc_seen_reg, disc_seen_next, disc_last_reg, disc_last_next;
    logic [31:0] last_pg_reg, last_pg_next;
    logic        stream_seen_reg, stream_seen_next;
    logic [31:0] stream_gen_reg, stream_gen_next;
    logic [32:0] exp_seq_reg, exp_seq_next;
    logic [31:0] cnt_reg [lhsm_pkg::NUM_CNT];
    logic [31:0] cnt_next [lhsm_pkg::NUM_CNT];
    logic [CW-1:0] base_fill_reg, base_fill_next, ring_fill_reg, ring_fill_next;
    logic [AW-1:0] head_reg, head_next;
    logic        win_reg, win_next;
    logic [4:0]  sel_reg, sel_next;
    logic [31:0] first_reg, first_next;

    logic        out_valid_reg, out_valid_next;
    logic        tvalid_reg, tvalid_next;
    logic [1:0]  old_reg, old_next, new_reg, new_next, reason_reg, reason_next;
    logic [31:0] tindex_reg, tindex_next;
    logic [32:0] rv_reg, rv_next;

    logic        accept, lat_store;
    logic [CW-1:0] final_cnt;
    logic [1:0]  nh;
    logic [32:0] loss_sum;
    logic [CW+6:0] cfg_ext;

    lhsm_pkg::p99_req_t req;
    lhsm_pkg::p99_rsp_t rsp;
    logic [CW-1:0] rd_idx;
    logic [CW:0]   fin_a;
    logic [AW-1:0] fin_addr;
    logic [31:0]   base_q, ring_q;

    assign cfg_ready = 1'b1;
    assign in_stall  = (phase_reg != P_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign final_cnt = (ring_fill_reg < ws_reg) ? ring_fill_reg : ws_reg;
    assign cfg_ext   = {{CW{1'b0}}, window_size};

    assign lat_store = accept && (func == lhsm_pkg::FUNC_PROBE) && discovery_up
                       && (rpc_code == lhsm_pkg::RPC_OK) && latency_present;

    always_comb
    begin
        if ({1'b0, rd_idx} < {{(CW+1-AW){1'b0}}, head_reg})
        begin
            fin_a = {{(CW+1-AW){1'b0}}, head_reg} - (CW+1)'(1) - {1'b0, rd_idx};
        end
        else
        begin
            fin_a = {{(CW+1-AW){1'b0}}, head_reg} + (CW+1)'(lhsm_pkg::MAX_WINDOW - 1)
                    - {1'b0, rd_idx};
        end
        fin_addr = fin_a[AW-1:0];
    end

    lhsm_ram #(.WIDTH(32), .DEPTH(lhsm_pkg::MAX_WINDOW)) u_base_ram (
        .clk   (clk),
        .we    (lat_store && (base_fill_reg < ws_reg)),
        .waddr (base_fill_reg[AW-1:0]),
        .wdata (latency_ns),
        .raddr (rd_idx[AW-1:0]),
        .rdata (base_q)
    );

    lhsm_ram #(.WIDTH(32), .DEPTH(lhsm_pkg::MAX_WINDOW)) u_ring_ram (
        .clk   (clk),
        .we    (lat_store),
        .waddr (head_reg),
        .wdata (latency_ns),
        .raddr (fin_addr),
        .rdata (ring_q)
    );

    lhsm_p99 u_p99 (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (win_reg ? ring_q : base_q),
        .rd_idx  (rd_idx),
        .rsp     (rsp)
    );

    always_comb
    begin
        phase_next       = phase_reg;
        ws_next          = ws_reg;
        health_next      = health_reg;
        fail_ep_next     = fail_ep_reg;
        disc_seen_next   = disc_seen_reg;
        disc_last_next   = disc_last_reg;
        last_pg_next     = last_pg_reg;
        stream_seen_next = stream_seen_reg;
        stream_gen_next  = stream_gen_reg;
        exp_seq_next     = exp_seq_reg;
        cnt_next         = cnt_reg;
        base_fill_next   = base_fill_reg;
        ring_fill_next   = ring_fill_reg;
        head_next        = head_reg;
        win_next         = win_reg;
        sel_next         = sel_reg;
        first_next       = first_reg;
        out_valid_next   = out_valid_reg && out_stall;
        tvalid_next      = tvalid_reg;
        old_next         = old_reg;
        new_next         = new_reg;
        reason_next      = reason_reg;
        tindex_next      = tindex_reg;
        rv_next          = rv_reg;
        req.start        = 1'b0;
        req.n            = base_fill_reg;
        nh               = health_reg;
        loss_sum         = '0;

        if (cfg_valid)
        begin
            if (window_size == 7'd0)
            begin
                ws_next = CW'(1);
            end
            else if (cfg_ext > (CW+7)'(lhsm_pkg::MAX_WINDOW))
            begin
                ws_next = CW'(lhsm_pkg::MAX_WINDOW);
            end
            else
            begin
                ws_next = cfg_ext[CW-1:0];
            end
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            tvalid_next    = 1'b0;
            old_next       = health_reg;
            new_next       = health_reg;
            reason_next    = lhsm_pkg::R_READY;
            tindex_next    = '0;
            rv_next        = '0;
            case (func)
                lhsm_pkg::FUNC_PROBE:
                begin
                    cnt_next[lhsm_pkg::C_PROBES] = lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_PROBES]);
                    if (!discovery_up)
                    begin
                        cnt_next[lhsm_pkg::C_DISC_FAIL] =
                            lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_DISC_FAIL]);
                    end
                    if (disc_seen_reg && (disc_last_reg != discovery_up))
                    begin
                        if (discovery_up)
                        begin
                            cnt_next[lhsm_pkg::C_DISC_RECOV] =
                                lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_DISC_RECOV]);
                        end
                        else
                        begin
                            cnt_next[lhsm_pkg::C_DISC_LOSS] =
                                lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_DISC_LOSS]);
                        end
                    end
                    disc_seen_next = 1'b1;
                    disc_last_next = discovery_up;
                    if (discovery_up && (peer_gen != '0))
                    begin
                        if ((last_pg_reg != '0) && (last_pg_reg != peer_gen))
                        begin
                            cnt_next[lhsm_pkg::C_PEER_CHG] =
                                lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_PEER_CHG]);
                        end
                        last_pg_next = peer_gen;
                    end
                    if (discovery_up)
                    begin
                        case (rpc_code) inside
                            lhsm_pkg::RPC_OK:
                            begin
                                cnt_next[lhsm_pkg::C_RPC_OK] =
                                    lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_RPC_OK]);
                            end
                            lhsm_pkg::RPC_TIMEOUT:
                            begin
                                cnt_next[lhsm_pkg::C_RPC_TIMEOUT] =
                                    lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_RPC_TIMEOUT]);
                            end
                            lhsm_pkg::RPC_CLOSED, lhsm_pkg::RPC_TRANSPORT:
                            begin
                                cnt_next[lhsm_pkg::C_RPC_TRANSPORT] =
                                    lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_RPC_TRANSPORT]);
                            end
                            [lhsm_pkg::RPC_OTHER_LO:lhsm_pkg::RPC_OTHER_HI]:
                            begin
                                cnt_next[lhsm_pkg::C_RPC_OTHER] =
                                    lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_RPC_OTHER]);
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    if (lat_store)
                    begin
                        cnt_next[lhsm_pkg::C_LAT_SAMPLES] =
                            lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_LAT_SAMPLES]);
                        if (base_fill_reg < ws_reg)
                        begin
                            base_fill_next = base_fill_reg + 1'b1;
                        end
                        head_next = (head_reg == AW'(lhsm_pkg::MAX_WINDOW - 1)) ?
                                    '0 : head_reg + 1'b1;
                        if (ring_fill_reg < CW'(lhsm_pkg::MAX_WINDOW))
                        begin
                            ring_fill_next = ring_fill_reg + 1'b1;
                        end
                    end
                    if (stream_seen_reg && !stream_recent)
                    begin
                        cnt_next[lhsm_pkg::C_STALL] = lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_STALL]);
                    end
                    if (!discovery_up)
                    begin
                        nh = lhsm_pkg::H_FAILED;
                        reason_next = lhsm_pkg::R_DISC_LOST;
                    end
                    else if (rpc_code != lhsm_pkg::RPC_OK)
                    begin
                        nh = lhsm_pkg::H_DEGRADED;
                        reason_next = lhsm_pkg::R_RPC_UNAVAIL;
                    end
                    else if (!stream_recent)
                    begin
                        nh = lhsm_pkg::H_DEGRADED;
                        reason_next = lhsm_pkg::R_STALLED;
                    end
                    else
                    begin
                        nh = lhsm_pkg::H_RUNNING;
                        reason_next = lhsm_pkg::R_READY;
                    end
                    if (nh == lhsm_pkg::H_FAILED)
                    begin
                        fail_ep_next = 1'b1;
                    end
                    if ((nh == lhsm_pkg::H_RUNNING) && fail_ep_reg)
                    begin
                        cnt_next[lhsm_pkg::C_RECOVERIES] =
                            lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_RECOVERIES]);
                        fail_ep_next = 1'b0;
                    end
                    tindex_next = lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_PROBES]);
                    if (nh != health_reg)
                    begin
                        tvalid_next = 1'b1;
                        health_next = nh;
                        cnt_next[lhsm_pkg::C_TRANSITIONS] =
                            lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_TRANSITIONS]);
                    end
                    new_next = nh;
                end
                lhsm_pkg::FUNC_MSG:
                begin
                    cnt_next[lhsm_pkg::C_MSGS] = lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_MSGS]);
                    if (!stream_seen_reg || (msg_generation > stream_gen_reg))
                    begin
                        stream_seen_next = 1'b1;
                        stream_gen_next  = msg_generation;
                        exp_seq_next     = {1'b0, msg_sequence} + 33'd1;
                    end
                    else if ((msg_generation < stream_gen_reg)
                             || ({1'b0, msg_sequence} < exp_seq_reg))
                    begin
                        cnt_next[lhsm_pkg::C_DUPS] = lhsm_pkg::sat_inc(cnt_reg[lhsm_pkg::C_DUPS]);
                    end
                    else
                    begin
                        if ({1'b0, msg_sequence} > exp_seq_reg)
                        begin
                            loss_sum = {1'b0, cnt_reg[lhsm_pkg::C_LOSS]}
                                       + {1'b0, msg_sequence - exp_seq_reg[31:0]};
                            cnt_next[lhsm_pkg::C_LOSS] = loss_sum[32] ? lhsm_pkg::SAT_MAX
                                                                      : loss_sum[31:0];
                        end
                        exp_seq_next = {1'b0, msg_sequence} + 33'd1;
                    end
                end
                lhsm_pkg::FUNC_PARSE:
                begin
                    if (parse_error_total > cnt_reg[lhsm_pkg::C_PARSE])
                    begin
                        cnt_next[lhsm_pkg::C_PARSE] = parse_error_total;
                    end
                end
                default:
                begin
                    sel_next = counter_select;
                    case (counter_select) inside
                        [lhsm_pkg::C_PROBES:lhsm_pkg::C_LAT_SAMPLES]:
                        begin
                            rv_next = {1'b0, cnt_reg[counter_select]};
                        end
                        lhsm_pkg::SEL_RETAINED:
                        begin
                            rv_next = 33'(base_fill_reg) + 33'(final_cnt);
                        end
                        lhsm_pkg::SEL_BASE_P99:
                        begin
                            out_valid_next = 1'b0;
                            req.start  = 1'b1;
                            req.n      = base_fill_reg;
                            win_next   = 1'b0;
                            phase_next = P_RUN1;
                        end
                        lhsm_pkg::SEL_FINAL_P99, lhsm_pkg::SEL_DRIFT:
                        begin
                            out_valid_next = 1'b0;
                            req.start  = 1'b1;
                            req.n      = final_cnt;
                            win_next   = 1'b1;
                            phase_next = P_RUN1;
                        end
                        lhsm_pkg::SEL_STATE:
                        begin
                            rv_next = {31'd0, health_reg};
                        end
                        default:
                        begin
                            rv_next = '0;
                        end
                    endcase
                end
            endcase
        end

        case (phase_reg)
            P_RUN1:
            begin
                if (rsp.done)
                begin
                    if (sel_reg == lhsm_pkg::SEL_DRIFT)
                    begin
                        first_next = rsp.value;
                        req.start  = 1'b1;
                        req.n      = base_fill_reg;
                        win_next   = 1'b0;
                        phase_next = P_RUN2;
                    end
                    else
                    begin
                        rv_next        = {1'b0, rsp.value};
                        out_valid_next = 1'b1;
                        phase_next     = P_IDLE;
                    end
                end
            end
            P_RUN2:
            begin
                if (rsp.done)
                begin
                    rv_next        = {1'b0, first_reg} - {1'b0, rsp.value};
                    out_valid_next = 1'b1;
                    phase_next     = P_IDLE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= P_IDLE;
            ws_reg          <= CW'(lhsm_pkg::MAX_WINDOW);
            health_reg      <= lhsm_pkg::H_STARTING;
            fail_ep_reg     <= 1'b0;
            disc_seen_reg   <= 1'b0;
            disc_last_reg   <= 1'b0;
            last_pg_reg     <= '0;
            stream_seen_reg <= 1'b0;
            stream_gen_reg  <= '0;
            exp_seq_reg     <= '0;
            for (int k = 0; k < lhsm_pkg::NUM_CNT; k++)
            begin
                cnt_reg[k] <= '0;
            end
            base_fill_reg   <= '0;
            ring_fill_reg   <= '0;
            head_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            ws_reg          <= ws_next;
            health_reg      <= health_next;
            fail_ep_reg     <= fail_ep_next;
            disc_seen_reg   <= disc_seen_next;
            disc_last_reg   <= disc_last_next;
            last_pg_reg     <= last_pg_next;
            stream_seen_reg <= stream_seen_next;
            stream_gen_reg  <= stream_gen_next;
            exp_seq_reg     <= exp_seq_next;
            cnt_reg         <= cnt_next;
            base_fill_reg   <= base_fill_next;
            ring_fill_reg   <= ring_fill_next;
            head_reg        <= head_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg    <= win_next;
        sel_reg    <= sel_next;
        first_reg  <= first_next;
        tvalid_reg <= tvalid_next;
        old_reg    <= old_next;
        new_reg    <= new_next;
        reason_reg <= reason_next;
        tindex_reg <= tindex_next;
        rv_reg     <= rv_next;
    end

    assign out_valid        = out_valid_reg;
    assign transition_valid = tvalid_reg;
    assign old_health       = old_reg;
    assign new_health       = new_reg;
    assign reason           = reason_reg;
    assign transition_index = tindex_reg;
    assign read_value       = rv_reg;

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != P_IDLE) |-> in_stall)
        else $error("input taken during p99 walk");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != P_IDLE) |-> !out_valid_reg)
        else $error("result pending while p99 walk runs");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ring_fill_reg <= CW'(lhsm_pkg::MAX_WINDOW)) && (base_fill_reg <= ws_reg
        || $past(cfg_valid) || !$stable(ws_reg) || base_fill_reg <= CW'(lhsm_pkg::MAX_WINDOW)))
        else $error("window fill out of range");

    a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (phase_reg != P_IDLE))
        else $error("p99 result with no read pending");

endmodule

/* hw/rtl/lhsm_ram.sv */
module lhsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/lhsm_p99.sv */
module lhsm_p99 (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lhsm_pkg::p99_req_t       req,
    input  logic [31:0]              rd_data,
    output logic [lhsm_pkg::CNT_W-1:0] rd_idx,
    output lhsm_pkg::p99_rsp_t       rsp
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CAND  = 6'b000010,
        S_LOAD  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_TAIL  = 6'b010000,
        S_CHECK = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [lhsm_pkg::CNT_W-1:0] n_reg, n_next, r_reg, r_next;
    logic [lhsm_pkg::CNT_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [lhsm_pkg::CNT_W-1:0] less_reg, less_next, leq_reg, leq_next;
    logic [31:0] cand_reg, cand_next, value_reg, value_next;
    logic pv_reg, pv_next, done_reg, done_next;
    logic lt, le;

    assign lt = rd_data < cand_reg;
    assign le = rd_data <= cand_reg;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        r_next     = r_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        less_next  = less_reg;
        leq_next   = leq_reg;
        cand_next  = cand_reg;
        value_next = value_reg;
        pv_next    = pv_reg;
        done_next  = 1'b0;
        rd_idx     = j_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    n_next = req.n;
                    r_next = lhsm_pkg::p99_rank(req.n);
                    i_next = '0;
                    if (req.n == '0)
                    begin
                        value_next = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = S_CAND;
                    end
                end
            end
            S_CAND:
            begin
                rd_idx     = i_reg;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cand_next  = rd_data;
                j_next     = '0;
                pv_next    = 1'b0;
                less_next  = '0;
                leq_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                rd_idx  = j_reg;
                pv_next = 1'b1;
                if (pv_reg)
                begin
                    less_next = less_reg + lhsm_pkg::CNT_W'(lt);
                    leq_next  = leq_reg + lhsm_pkg::CNT_W'(le);
                end
                if (j_reg == n_reg - 1'b1)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_TAIL:
            begin
                less_next  = less_reg + lhsm_pkg::CNT_W'(lt);
                leq_next   = leq_reg + lhsm_pkg::CNT_W'(le);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if ((less_reg < r_reg) && (leq_reg >= r_reg))
                begin
                    value_next = cand_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_CAND;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        r_reg     <= r_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        less_reg  <= less_next;
        leq_reg   <= leq_next;
        cand_reg  <= cand_next;
        value_reg <= value_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

/* bench/link_health_and_sequence_monitor_checker.sv */
module link_health_and_sequence_monitor_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [6:0]  window_size,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  func,
    input  logic        discovery_up,
    input  logic [31:0] peer_gen,
    input  logic [3:0]  rpc_code,
    input  logic        latency_present,
    input  logic [31:0] latency_ns,
    input  logic        stream_recent,
    input  logic [31:0] msg_generation,
    input  logic [31:0] msg_sequence,
    input  logic [31:0] parse_error_total,
    input  logic [4:0]  counter_select,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        transition_valid,
    input  logic [1:0]  old_health,
    input  logic [1:0]  new_health,
    input  logic [1:0]  reason,
    input  logic [31:0] transition_index,
    input  logic signed [32:0] read_value,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIFO_DEPTH = 16;

    typedef struct packed {
        logic        tvalid;
        logic [1:0]  old_h;
        logic [1:0]  new_h;
        logic [1:0]  why;
        logic [31:0] tidx;
        logic [32:0] rval;
    } monitor_result_t;

    monitor_result_t expected_results [FIFO_DEPTH];
    int          wr_count = 0;
    int          rd_count = 0;

    logic [6:0]  win;
    logic [1:0]  hstate;
    logic        in_failure;
    logic        disc_seen, disc_last;
    logic [31:0] peer_last;
    logic        strm_seen;
    logic [31:0] strm_gen;
    logic [32:0] next_seq;
    logic [31:0] counters [lhsm_pkg::NUM_CNT];
    logic [31:0] base_lat [lhsm_pkg::MAX_WINDOW];
    logic [6:0]  base_fill;
    logic [31:0] ring_lat [lhsm_pkg::MAX_WINDOW];
    logic [5:0]  head;
    logic [6:0]  rfill;

    assign pending_count = wr_count - rd_count;

    function automatic logic [31:0] sat_add(logic [31:0] v, logic [32:0] amt);
        logic [33:0] s;
        s = {2'b0, v} + {1'b0, amt};
        return (s > 34'(lhsm_pkg::SAT_MAX)) ? lhsm_pkg::SAT_MAX : s[31:0];
    endfunction

    function automatic logic [31:0] rank_pick(logic [31:0] vals [lhsm_pkg::MAX_WINDOW],
                                              int n);
        logic [31:0] key;
        int j;
        int r;
        if (n == 0)
            return 32'd0;
        for (int i = 1; i < n; i++) begin
            key = vals[i];
            j = i;
            while (j > 0 && vals[j - 1] > key) begin
                vals[j] = vals[j - 1];
                j--;
            end
            vals[j] = key;
        end
        r = (99 * n + 99) / 100;
        if (r < 1) r = 1;
        if (r > n) r = n;
        return vals[r - 1];
    endfunction

    function automatic logic [6:0] final_len();
        return (rfill < win) ? rfill : win;
    endfunction

    function automatic logic [31:0] baseline_p99_ns();
        return rank_pick(base_lat, int'(base_fill));
    endfunction

    function automatic logic [31:0] final_p99_ns();
        logic [31:0] v [lhsm_pkg::MAX_WINDOW];
        int n;
        n = int'(final_len());
        for (int i = 0; i < n; i++)
            v[i] = ring_lat[6'(head - 6'd1 - 6'(i))];
        return rank_pick(v, n);
    endfunction

    function automatic logic [32:0] select_value(logic [4:0] sel);
        if (sel < 5'(lhsm_pkg::NUM_CNT))
            return {1'b0, counters[sel]};
        case (sel)
            lhsm_pkg::SEL_RETAINED:  return 33'(base_fill) + 33'(final_len());
            lhsm_pkg::SEL_BASE_P99:  return {1'b0, baseline_p99_ns()};
            lhsm_pkg::SEL_FINAL_P99: return {1'b0, final_p99_ns()};
            lhsm_pkg::SEL_DRIFT:     return {1'b0, final_p99_ns()} - {1'b0, baseline_p99_ns()};
            lhsm_pkg::SEL_STATE:     return 33'(hstate);
            default:                 return 33'd0;
        endcase
    endfunction

    task automatic bump(logic [4:0] idx);
        counters[idx] = sat_add(counters[idx], 33'd1);
    endtask

    task automatic record_latency(logic [31:0] lat);
        bump(lhsm_pkg::C_LAT_SAMPLES);
        if (base_fill < win) begin
            base_lat[base_fill] = lat;
            base_fill++;
        end
        ring_lat[head] = lat;
        head++;
        if (rfill < 7'(lhsm_pkg::MAX_WINDOW))
            rfill++;
    endtask

    task automatic predict_item();
        monitor_result_t r;
        logic [1:0] nxt;
        r = '0;
        r.old_h = hstate;
        case (func)
            lhsm_pkg::FUNC_PROBE: begin
                bump(lhsm_pkg::C_PROBES);
                if (!discovery_up)
                    bump(lhsm_pkg::C_DISC_FAIL);
                if (disc_seen && disc_last != discovery_up)
                    bump(discovery_up ? lhsm_pkg::C_DISC_RECOV : lhsm_pkg::C_DISC_LOSS);
                disc_seen = 1'b1;
                disc_last = discovery_up;
                if (discovery_up && peer_gen != 32'd0) begin
                    if (peer_last != 32'd0 && peer_last != peer_gen)
                        bump(lhsm_pkg::C_PEER_CHG);
                    peer_last = peer_gen;
                end
                if (discovery_up) begin
                    if (rpc_code == lhsm_pkg::RPC_OK) begin
                        bump(lhsm_pkg::C_RPC_OK);
                        if (latency_present)
                            record_latency(latency_ns);
                    end else if (rpc_code == lhsm_pkg::RPC_TIMEOUT)
                        bump(lhsm_pkg::C_RPC_TIMEOUT);
                    else if (rpc_code == lhsm_pkg::RPC_CLOSED
                             || rpc_code == lhsm_pkg::RPC_TRANSPORT)
                        bump(lhsm_pkg::C_RPC_TRANSPORT);
                    else if (rpc_code <= lhsm_pkg::RPC_OTHER_HI)
                        bump(lhsm_pkg::C_RPC_OTHER);
                end
                if (strm_seen && !stream_recent)
                    bump(lhsm_pkg::C_STALL);
                if (!discovery_up) begin
                    nxt = lhsm_pkg::H_FAILED; r.why = lhsm_pkg::R_DISC_LOST;
                end else if (rpc_code != lhsm_pkg::RPC_OK) begin
                    nxt = lhsm_pkg::H_DEGRADED; r.why = lhsm_pkg::R_RPC_UNAVAIL;
                end else if (!stream_recent) begin
                    nxt = lhsm_pkg::H_DEGRADED; r.why = lhsm_pkg::R_STALLED;
                end else begin
                    nxt = lhsm_pkg::H_RUNNING; r.why = lhsm_pkg::R_READY;
                end
                if (nxt == lhsm_pkg::H_FAILED)
                    in_failure = 1'b1;
                if (nxt == lhsm_pkg::H_RUNNING && in_failure) begin
                    bump(lhsm_pkg::C_RECOVERIES);
                    in_failure = 1'b0;
                end
                r.tidx = counters[lhsm_pkg::C_PROBES];
                if (nxt != hstate) begin
                    r.tvalid = 1'b1;
                    hstate = nxt;
                    bump(lhsm_pkg::C_TRANSITIONS);
                end
            end
            lhsm_pkg::FUNC_MSG: begin
                bump(lhsm_pkg::C_MSGS);
                if (!strm_seen || msg_generation > strm_gen) begin
                    strm_seen = 1'b1;
                    strm_gen = msg_generation;
                    next_seq = {1'b0, msg_sequence} + 33'd1;
                end else if (msg_generation < strm_gen || {1'b0, msg_sequence} < next_seq)
                    bump(lhsm_pkg::C_DUPS);
                else begin
                    if ({1'b0, msg_sequence} > next_seq)
                        counters[lhsm_pkg::C_LOSS] = sat_add(counters[lhsm_pkg::C_LOSS],
                                                   {1'b0, msg_sequence} - next_seq);
                    next_seq = {1'b0, msg_sequence} + 33'd1;
                end
            end
            lhsm_pkg::FUNC_PARSE: begin
                if (parse_error_total > counters[lhsm_pkg::C_PARSE])
                    counters[lhsm_pkg::C_PARSE] = parse_error_total;
            end
            default: r.rval = select_value(counter_select);
        endcase
        r.new_h = hstate;
        if (wr_count - rd_count >= FIFO_DEPTH) begin
            $display("%0t: too many results outstanding", $realtime);
            fail_count++;
        end else begin
            expected_results[wr_count % FIFO_DEPTH] = r;
            wr_count++;
        end
    endtask

    task automatic report_mismatch(string what, logic [32:0] got, logic [32:0] want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic compare_result();
        monitor_result_t e;
        if (wr_count == rd_count) begin
            $display("%0t: result with nothing pending", $realtime);
            fail_count++;
            return;
        end
        e = expected_results[rd_count % FIFO_DEPTH];
        rd_count++;
        if (transition_valid !== e.tvalid)
            report_mismatch("transition_valid", 33'(transition_valid), 33'(e.tvalid));
        if (old_health !== e.old_h)
            report_mismatch("old_health", 33'(old_health), 33'(e.old_h));
        if (new_health !== e.new_h)
            report_mismatch("new_health", 33'(new_health), 33'(e.new_h));
        if (reason !== e.why)
            report_mismatch("reason", 33'(reason), 33'(e.why));
        if (transition_index !== e.tidx)
            report_mismatch("transition_index", 33'(transition_index), 33'(e.tidx));
        if (read_value !== e.rval)
            report_mismatch("read_value", read_value, e.rval);
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            win = 7'd64;
            hstate = lhsm_pkg::H_STARTING;
            in_failure = 1'b0; disc_seen = 1'b0; disc_last = 1'b0; peer_last = '0;
            strm_seen = 1'b0; strm_gen = '0; next_seq = '0;
            for (int i = 0; i < lhsm_pkg::NUM_CNT; i++)
                counters[i] = '0;
            base_fill = '0; head = '0; rfill = '0;
        end else begin
            if (cfg_valid && cfg_ready)
                win = (window_size == 7'd0) ? 7'd1
                    : (window_size > 7'(lhsm_pkg::MAX_WINDOW)) ? 7'(lhsm_pkg::MAX_WINDOW)
                    : window_size;
            if (out_valid && !out_stall)
                compare_result();
            if (in_valid && !in_stall)
                predict_item();
        end
    end
endmodule

/* bench/link_health_and_sequence_monitor_tb.sv */
module link_health_and_sequence_monitor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk, rst_n;
    logic        cfg_valid, cfg_ready;
    logic [6:0]  window_size;
    logic        in_valid, in_stall;
    logic [1:0]  func;
    logic        discovery_up;
    logic [31:0] peer_gen;
    logic [3:0]  rpc_code;
    logic        latency_present;
    logic [31:0] latency_ns;
    logic        stream_recent;
    logic [31:0] msg_generation, msg_sequence, parse_error_total;
    logic [4:0]  counter_select;
    logic        out_valid, out_stall;
    logic        transition_valid;
    logic [1:0]  old_health, new_health, reason;
    logic [31:0] transition_index;
    logic signed [32:0] read_value;
    int          fail_count, pending_count;
    bit          hold_output;
    logic [31:0] gen_now, seq_now;

    link_health_and_sequence_monitor dut (.*);
    link_health_and_sequence_monitor_checker checker_i (.*);

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_output) out_stall <= 1'b1;
            else if ($urandom_range(0, 99) < 70) out_stall <= 1'b0;
            else out_stall <= (gap_len() > 0);
        end
    end

    task automatic wait_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
    endtask

    task automatic send_item(logic [1:0] f, logic d, logic [31:0] pg, logic [3:0] st,
                             logic lp, logic [31:0] lat, logic sr, logic [31:0] mg,
                             logic [31:0] ms, logic [31:0] pe, logic [4:0] sel);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            wait_cycles(g);
        end
        func <= f; discovery_up <= d; peer_gen <= pg; rpc_code <= st;
        latency_present <= lp; latency_ns <= lat; stream_recent <= sr;
        msg_generation <= mg; msg_sequence <= ms; parse_error_total <= pe;
        counter_select <= sel; in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic probe(logic d, logic [3:0] st, logic sr, logic [31:0] lat);
        send_item(lhsm_pkg::FUNC_PROBE, d, $urandom_range(0, 3), st,
                  $urandom_range(0, 4) != 0, lat, sr, $urandom, $urandom, $urandom,
                  5'($urandom));
    endtask

    task automatic read_sel(logic [4:0] sel);
        send_item(lhsm_pkg::FUNC_READ, 1'($urandom), $urandom, 4'($urandom),
                  1'($urandom), $urandom, 1'($urandom), $urandom, $urandom, $urandom,
                  sel);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    task automatic drain_and_set(logic [6:0] w);
        idle_input();
        wait_drained();
        wait_cycles(20);
        window_size <= w; cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int p;
        logic [31:0] big;
        p = $urandom_range(0, 99);
        big = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1000, 5000);
        if (p < 50)
            send_item(lhsm_pkg::FUNC_PROBE, $urandom_range(0, 5) != 0,
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3),
                      ($urandom_range(0, 2) == 0) ? 4'($urandom) : lhsm_pkg::RPC_OK,
                      1'($urandom), big, $urandom_range(0, 4) != 0,
                      $urandom, $urandom, $urandom, 5'($urandom));
        else if (p < 75) begin
            p = $urandom_range(0, 9);
            if (p == 0) gen_now = gen_now + $urandom_range(1, 2);
            else if (p == 1) gen_now = gen_now - 32'd1;
            if (p == 2) seq_now = seq_now - $urandom_range(0, 3);
            else if (p == 3) seq_now = seq_now + $urandom_range(2, 9);
            else if (p == 4) seq_now = $urandom;
            else seq_now = seq_now + 32'd1;
            send_item(lhsm_pkg::FUNC_MSG, 1'($urandom), $urandom, 4'($urandom),
                      1'($urandom), $urandom, 1'($urandom), gen_now, seq_now,
                      $urandom, 5'($urandom));
        end else if (p < 82)
            send_item(lhsm_pkg::FUNC_PARSE, 1'($urandom), $urandom, 4'($urandom),
                      1'($urandom), $urandom, 1'($urandom), $urandom, $urandom,
                      ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 400),
                      5'($urandom));
        else if (p < 93)
            read_sel(5'($urandom_range(0, 17)));
        else
            read_sel(5'($urandom_range(18, 31)));
    endtask

    initial begin
        rst_n = 1'b0; cfg_valid = 1'b0; window_size = '0; in_valid = 1'b0;
        func = '0; discovery_up = 1'b0; peer_gen = '0; rpc_code = '0;
        latency_present = 1'b0; latency_ns = '0; stream_recent = 1'b0;
        msg_generation = '0; msg_sequence = '0; parse_error_total = '0;
        counter_select = '0; hold_output = 1'b0; gen_now = 32'd5; seq_now = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        read_sel(lhsm_pkg::SEL_BASE_P99);
        read_sel(lhsm_pkg::SEL_DRIFT);
        probe(1'b1, lhsm_pkg::RPC_OK, 1'b1, 32'hFFFF_FFFF);
        probe(1'b1, lhsm_pkg::RPC_OK, 1'b1, 32'd0);
        probe(1'b0, lhsm_pkg::RPC_OK, 1'b1, 32'd7);
        probe(1'b1, lhsm_pkg::RPC_TIMEOUT, 1'b1, 32'd7);
        probe(1'b1, lhsm_pkg::RPC_TRANSPORT, 1'b0, 32'd7);
        probe(1'b1, lhsm_pkg::RPC_OTHER_HI, 1'b1, 32'd7);
        probe(1'b1, 4'd15, 1'b1, 32'd7);
        probe(1'b1, lhsm_pkg::RPC_OK, 1'b0, 32'd7);
        probe(1'b1, lhsm_pkg::RPC_OK, 1'b1, 32'd9);
        send_item(lhsm_pkg::FUNC_MSG, 1'b0, 32'd0, lhsm_pkg::RPC_OK, 1'b0, 32'd0, 1'b0,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 5'd0);
        send_item(lhsm_pkg::FUNC_MSG, 1'b0, 32'd0, lhsm_pkg::RPC_OK, 1'b0, 32'd0, 1'b0,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 5'd0);
        send_item(lhsm_pkg::FUNC_MSG, 1'b0, 32'd0, lhsm_pkg::RPC_OK, 1'b0, 32'd0, 1'b0,
                  32'd0, 32'd0, 32'd0, 5'd0);
        send_item(lhsm_pkg::FUNC_MSG, 1'b1, 32'd1, lhsm_pkg::RPC_TIMEOUT, 1'b1, 32'd1, 1'b1,
                  32'hFFFF_FFFF, 32'd5, 32'hFFFF_FFFF, 5'h1F);
        send_item(lhsm_pkg::FUNC_PARSE, 1'b0, 32'd0, lhsm_pkg::RPC_OK, 1'b0, 32'd0, 1'b0,
                  32'd0, 32'd0, 32'hFFFF_FFFF, 5'd0);
        send_item(lhsm_pkg::FUNC_PARSE, 1'b0, 32'd0, lhsm_pkg::RPC_OK, 1'b0, 32'd0, 1'b0,
                  32'd0, 32'd0, 32'd3, 5'd0);
        for (int s = 0; s < 32; s += 3)
            read_sel(5'(s));
        read_sel(lhsm_pkg::SEL_STATE);

        drain_and_set(7'd0);
        for (int i = 0; i < 250; i++) random_item();
        read_sel(lhsm_pkg::SEL_DRIFT);
        drain_and_set(7'd127);
        for (int i = 0; i < 350; i++) random_item();
        drain_and_set(7'd3);
        fork
            begin
                for (int i = 0; i < 40; i++) random_item();
                idle_input();
            end
            begin
                hold_output = 1'b1;
                wait_cycles(200);
                hold_output = 1'b0;
            end
        join
        for (int i = 0; i < 300; i++) random_item();
        drain_and_set(7'd17);
        for (int i = 0; i < 350; i++) random_item();
        read_sel(lhsm_pkg::SEL_BASE_P99);
        read_sel(lhsm_pkg::SEL_FINAL_P99);
        read_sel(lhsm_pkg::SEL_DRIFT);
        idle_input();

        wait_drained();
        wait_cycles(30);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* link_health_and_sequence_monitor.f */
hw/rtl/lhsm_pkg.sv
hw/rtl/lhsm_ram.sv
hw/rtl/lhsm_p99.sv
hw/rtl/link_health_and_sequence_monitor.sv
bench/link_health_and_sequence_monitor_checker.sv
bench/link_health_and_sequence_monitor_tb.sv
